/* sv/utf8_stream_validator_top_macros.svh */
`ifndef UTF8_STREAM_VALIDATOR_TOP_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define U8V_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utf8 validator check failed");

// next-cycle implication, checked out of reset
`define U8V_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8 validator check failed");

`endif

/* sv/utf8v_pkg.sv */
`default_nettype none

package utf8v_pkg;

  localparam int unsigned LANES = 8;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned IN_TDATA_W = 72;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [7:0] LEAD_MAX = 8'hF4;
  localparam logic [7:0] LEAD_SURR = 8'hED;
  localparam logic [7:0] SURR_MAX = 8'h9F;
  localparam logic [7:0] PLANE_MAX = 8'h8F;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] OVL_C0 = 8'hC0;
  localparam logic [7:0] OVL_C1 = 8'hC1;
  localparam logic [7:0] E0_MIN = 8'hA0;
  localparam logic [7:0] F0_MIN = 8'h90;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LANES);

  typedef logic [1:0] pend_t;

  typedef struct packed {
    pend_t [3:0] nxt;
    logic  [3:0] err;
  } lane_res_t;

endpackage

`default_nettype wire

/* sv/utf8v_lane.sv */
`default_nettype none

module utf8v_lane (
  input  logic                  en_i,
  input  logic [7:0]            byte_i,
  input  logic [7:0]            prev_i,
  output utf8v_pkg::lane_res_t  res_o
);
  import utf8v_pkg::*;

  logic  is_cont;
  logic  base_err;
  logic  fresh_err;
  logic  cont_err;
  pend_t fresh_nxt;

  always_comb begin
    is_cont   = (byte_i[7:6] == 2'b10);
    base_err  = (byte_i > LEAD_MAX);
    fresh_err = is_cont || (byte_i == OVL_C0) || (byte_i == OVL_C1);
    cont_err  = ((prev_i == LEAD3_MIN) && (byte_i < E0_MIN))
             || ((prev_i == LEAD_SURR) && (byte_i > SURR_MAX))
             || ((prev_i == LEAD4_MIN) && (byte_i < F0_MIN))
             || ((prev_i == LEAD_MAX) && (byte_i > PLANE_MAX));
    if (byte_i >= LEAD2_MIN && byte_i <= LEAD2_MAX) begin
      fresh_nxt = 2'd1;
    end else if (byte_i >= LEAD3_MIN && byte_i <= LEAD3_MAX) begin
      fresh_nxt = 2'd2;
    end else if (byte_i >= LEAD4_MIN && byte_i <= LEAD_MAX) begin
      fresh_nxt = 2'd3;
    end else begin
      fresh_nxt = 2'd0;
    end
  end

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      if (!en_i) begin
        res_o.nxt[p] = pend_t'(p);
        res_o.err[p] = 1'b0;
      end else if (p == 0) begin
        res_o.nxt[p] = fresh_nxt;
        res_o.err[p] = base_err || fresh_err;
      end else if (is_cont) begin
        res_o.nxt[p] = pend_t'(p - 1);
        res_o.err[p] = base_err || cont_err;
      end else begin
        res_o.nxt[p] = fresh_nxt;
        res_o.err[p] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/utf8v_merge.sv */
`default_nettype none

module utf8v_merge (
  input  utf8v_pkg::lane_res_t [utf8v_pkg::LANES-1:0] res_i,
  input  utf8v_pkg::pend_t                             pend_i,
  input  logic                                         err_i,
  input  logic                                         last_i,
  output utf8v_pkg::pend_t                             pend_o,
  output logic                                         err_o
);
  import utf8v_pkg::*;

  pend_t p;
  logic  e;

  always_comb begin
    p = pend_i;
    e = err_i;
    for (int k = 0; k < LANES; k++) begin
      e = e || res_i[k].err[p];
      p = res_i[k].nxt[p];
    end
    if (last_i && (p != 2'd0)) begin
      e = 1'b1;
    end
    pend_o = p;
    err_o  = e;
  end

endmodule

`default_nettype wire

/* sv/utf8_stream_validator_top.sv */
// channel  | dir | tdata (low bit up)                 | tlast       | tuser
// s_axis   | in  | data_bytes[63:0] byte_count[67:64] | last_chunk  | -
// m_axis   | out | error_seen[0] text_valid[1]        | end_of_text | -
//
// One chunk per cycle while the output is not stalled; each result passes the lane register and the output register.
// Eight lanes classify the bytes of a chunk against every possible carried-in
// sequence state; the merge stage chains those maps and carries the state.
// Reset clears the pipeline, the carried state and the sticky error flag.
// A stalled output holds its beat; the input stalls only when both stages are full.
`default_nettype none
`include "utf8_stream_validator_top_macros.svh"

module utf8_stream_validator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [utf8v_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // data_bytes, byte_count, pad
  input  logic                              s_axis_tlast,  // last_chunk
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [utf8v_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // error_seen, text_valid, pad
  output logic                              m_axis_tlast   // end_of_text
);
  import utf8v_pkg::*;

  logic [LANES*8-1:0] in_bytes;
  logic [CNT_W-1:0]   in_cnt;
  logic [CNT_W-1:0]   cnt_sat;
  logic [7:0]         last_byte;
  logic               have_byte;
  logic [7:0]         prev_q, prev_d;

  lane_res_t [LANES-1:0] lane_res;
  lane_res_t [LANES-1:0] s1_res_q;
  logic                  s1_vld_q;
  logic                  s1_last_q;

  pend_t pend_q, pend_d;
  logic  err_q, err_d;

  logic out_vld_q;
  logic out_err_q;
  logic out_ok_q;
  logic out_last_q;

  logic out_adv;
  logic s1_adv;
  logic s_acc;
  logic s1_move;

  assign in_bytes = s_axis_tdata[LANES*8-1:0];
  assign in_cnt   = s_axis_tdata[64 +: CNT_W];
  assign cnt_sat  = (in_cnt > CNT_MAX) ? CNT_MAX : in_cnt;

  assign out_adv       = !out_vld_q || m_axis_tready;
  assign s1_adv        = !s1_vld_q || out_adv;
  assign s_axis_tready = s1_adv;
  assign s_acc         = s_axis_tvalid && s1_adv;
  assign s1_move       = s1_vld_q && out_adv;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [7:0] pb;
    if (k == 0) begin : g_first
      assign pb = prev_q;
    end else begin : g_rest
      assign pb = in_bytes[8*(k-1) +: 8];
    end
    utf8v_lane u_lane (
      .en_i   (CNT_W'(k) < cnt_sat),
      .byte_i (in_bytes[8*k +: 8]),
      .prev_i (pb),
      .res_o  (lane_res[k])
    );
  end

  always_comb begin
    last_byte = 8'h00;
    have_byte = 1'b0;
    for (int k = 0; k < LANES; k++) begin
      if (CNT_W'(k + 1) == cnt_sat) begin
        last_byte = in_bytes[8*k +: 8];
        have_byte = 1'b1;
      end
    end
    if (s_axis_tlast) begin
      prev_d = 8'h00;
    end else if (have_byte) begin
      prev_d = last_byte;
    end else begin
      prev_d = prev_q;
    end
  end

  utf8v_merge u_merge (
    .res_i  (s1_res_q),
    .pend_i (pend_q),
    .err_i  (err_q),
    .last_i (s1_last_q),
    .pend_o (pend_d),
    .err_o  (err_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= 8'h00;
      s1_vld_q   <= 1'b0;
      s1_last_q  <= 1'b0;
      pend_q     <= 2'd0;
      err_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      out_err_q  <= 1'b0;
      out_ok_q   <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (s_acc) begin
        prev_q    <= prev_d;
        s1_last_q <= s_axis_tlast;
      end
      if (s1_adv) begin
        s1_vld_q <= s_axis_tvalid;
      end
      if (s1_move) begin
        pend_q     <= s1_last_q ? 2'd0 : pend_d;
        err_q      <= s1_last_q ? 1'b0 : err_d;
        out_err_q  <= err_d;
        out_ok_q   <= s1_last_q && !err_d;
        out_last_q <= s1_last_q;
      end
      if (out_adv) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_res_q <= lane_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, out_ok_q, out_err_q};
  assign m_axis_tlast  = out_last_q;

  `U8V_ASSERT_NOW(a_ok_only_clean_end, out_vld_q && out_ok_q, out_last_q && !out_err_q)
  `U8V_ASSERT_NEXT(a_clear_after_end, s1_move && s1_last_q, pend_q == 2'd0 && err_q == 1'b0)
  `U8V_ASSERT_NEXT(a_error_sticky, err_q && !(s1_move && s1_last_q), err_q)
  `U8V_ASSERT_NEXT(a_stage_holds, s1_vld_q && !out_adv, s1_vld_q && $stable(s1_res_q))

endmodule

`default_nettype wire
